// File: design/plm_interface_reconstruct_core_defines.svh
// Assertion macros for the interface reconstruction core.
`ifndef PLM_INTERFACE_RECONSTRUCT_CORE_DEFINES_SVH
`define PLM_INTERFACE_RECONSTRUCT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PLMIR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("plmir check failed");
`define PLMIR_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("plmir reset check failed");
`else
`define PLMIR_ASSERT(lbl, prop)
`define PLMIR_ASSERT_RST(lbl, prop)
`endif
`endif

// File: design/plmir_pkg.sv
// Shared types, constants, arithmetic helpers and micro-program of the reconstruction core.
package plmir_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;

	localparam word_t MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t MINV = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t ONE_Q = word_t'(64'd1 << FRAC_BITS);
	localparam word_t HALF_Q = word_t'(64'd1 << (FRAC_BITS - 1));

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DTDX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA = 2'd3;

	localparam logic [18:0] GAMMA_RST = 19'd109227;
	localparam logic [30:0] DTDX_RST = 31'd6554;
	localparam logic [16:0] FLOOR_RST = 17'd1;
	localparam logic [17:0] BETA_RST = 18'd65536;

	typedef struct packed {
		word_t density;
		word_t momentum_x;
		word_t momentum_y;
		word_t momentum_z;
		word_t energy;
		logic  row_start;
	} cell_t;

	typedef struct packed {
		word_t left_density;
		word_t left_mom_x;
		word_t left_mom_y;
		word_t left_mom_z;
		word_t left_energy;
		word_t right_density;
		word_t right_mom_x;
		word_t right_mom_y;
		word_t right_mom_z;
		word_t right_energy;
	} iface_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN, OP_SEL, OP_BR, OP_END
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] a;
		logic [6:0] b;
		logic [6:0] dst;
	} mop_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic ex;
		logic wb;
		logic publish;
		mop_t mop;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sts_t;

	// operand sources at and above 64 are constants, registers and input fields
	localparam logic [6:0] S_ZERO = 7'd64;
	localparam logic [6:0] S_HALF = 7'd65;
	localparam logic [6:0] S_ONE = 7'd66;
	localparam logic [6:0] S_GAMMA = 7'd67;
	localparam logic [6:0] S_FL = 7'd68;
	localparam logic [6:0] S_BETA = 7'd69;
	localparam logic [6:0] S_DTDX = 7'd70;
	localparam logic [6:0] S_IN0 = 7'd71;
	localparam logic [6:0] S_IN1 = 7'd72;
	localparam logic [6:0] S_IN2 = 7'd73;
	localparam logic [6:0] S_IN3 = 7'd74;
	localparam logic [6:0] S_IN4 = 7'd75;
	// destinations at and above 64 are result fields
	localparam logic [6:0] D_OUT = 7'd64;

	localparam logic [7:0] PC_B = 8'd32;
	localparam logic [7:0] PC_C = 8'd112;
	localparam logic [7:0] PC_SH = 8'd173;
	localparam logic [7:0] PC_END = 8'd183;

	function automatic logic [WORD_BITS-1:0] mag(input word_t x);
		return x[WORD_BITS-1] ? ((WORD_BITS)'(0) - x) : x;
	endfunction

	function automatic word_t sat_mag(input logic neg, input logic [DIV_STEPS-1:0] m);
		logic [DIV_STEPS-1:0] lim;
		lim = DIV_STEPS'(MAXV);
		if (!neg)
			return (m > lim) ? MAXV : word_t'(m[WORD_BITS-1:0]);
		return (m > lim + 1'b1) ? MINV : word_t'((WORD_BITS)'(0) - m[WORD_BITS-1:0]);
	endfunction

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1])
			return s[WORD_BITS] ? MINV : MAXV;
		return s[WORD_BITS-1:0];
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1])
			return s[WORD_BITS] ? MINV : MAXV;
		return s[WORD_BITS-1:0];
	endfunction

	function automatic mop_t mo(input op_t op, input logic [6:0] a, input logic [6:0] b,
			input logic [6:0] d);
		mop_t m;
		m.op = op;
		m.a = a;
		m.b = b;
		m.dst = d;
		return m;
	endfunction

	function automatic mop_t mop(input logic [7:0] pc);
		mop_t m;
		logic [7:0] off;
		logic [6:0] i7, mid, old, cur, lft, rgt;
		m = mo(OP_NOP, S_ZERO, S_ZERO, 7'd0);
		off = 8'd0;
		i7 = 7'd0;
		if (pc < PC_B) begin
			case (pc[4:0])
				5'd0: m = mo(OP_SUB, S_GAMMA, S_ONE, 7'd15);
				5'd1: m = mo(OP_ADD, S_IN0, S_ZERO, 7'd10);
				5'd2: m = mo(OP_DIV, S_IN1, 7'd10, 7'd11);
				5'd3: m = mo(OP_DIV, S_IN2, 7'd10, 7'd12);
				5'd4: m = mo(OP_DIV, S_IN3, 7'd10, 7'd13);
				5'd5: m = mo(OP_MUL, 7'd11, 7'd11, 7'd16);
				5'd6: m = mo(OP_MUL, 7'd12, 7'd12, 7'd17);
				5'd7: m = mo(OP_ADD, 7'd16, 7'd17, 7'd16);
				5'd8: m = mo(OP_MUL, 7'd13, 7'd13, 7'd17);
				5'd9: m = mo(OP_ADD, 7'd16, 7'd17, 7'd16);
				5'd10: m = mo(OP_MUL, S_HALF, 7'd10, 7'd17);
				5'd11: m = mo(OP_MUL, 7'd17, 7'd16, 7'd17);
				5'd12: m = mo(OP_SUB, S_IN4, 7'd17, 7'd17);
				5'd13: m = mo(OP_MUL, 7'd17, 7'd15, 7'd17);
				5'd14: m = mo(OP_MAX, 7'd17, S_FL, 7'd14);
				5'd15: m = mo(OP_BR, S_ZERO, S_ZERO, 7'd0);
				default: m = mo(OP_NOP, S_ZERO, S_ZERO, 7'd0);
			endcase
		end else if (pc < PC_C) begin
			off = pc - PC_B;
			i7 = {4'd0, off[6:4]};
			mid = 7'd5 + i7;
			old = i7;
			cur = 7'd10 + i7;
			lft = 7'd25 + i7;
			rgt = 7'd30 + i7;
			case (off[3:0])
				4'd0: m = mo(OP_SUB, mid, old, 7'd18);
				4'd1: m = mo(OP_SUB, cur, mid, 7'd19);
				4'd2: m = mo(OP_MUL, S_BETA, 7'd18, 7'd20);
				4'd3: m = mo(OP_MUL, S_BETA, 7'd19, 7'd21);
				4'd4: m = mo(OP_MIN, 7'd20, 7'd19, 7'd22);
				4'd5: m = mo(OP_MAX, S_ZERO, 7'd22, 7'd22);
				4'd6: m = mo(OP_MIN, 7'd18, 7'd21, 7'd23);
				4'd7: m = mo(OP_MAX, 7'd22, 7'd23, 7'd22);
				4'd8: m = mo(OP_MAX, 7'd20, 7'd19, 7'd23);
				4'd9: m = mo(OP_MIN, S_ZERO, 7'd23, 7'd23);
				4'd10: m = mo(OP_MAX, 7'd18, 7'd21, 7'd24);
				4'd11: m = mo(OP_MIN, 7'd23, 7'd24, 7'd23);
				4'd12: m = mo(OP_SEL, 7'd22, 7'd23, 7'd22);
				4'd13: m = mo(OP_MUL, S_HALF, 7'd22, 7'd22);
				4'd14: m = mo(OP_SUB, mid, 7'd22, lft);
				4'd15: m = mo(OP_ADD, mid, 7'd22, rgt);
				default: m = mo(OP_NOP, S_ZERO, S_ZERO, 7'd0);
			endcase
		end else if (pc < PC_SH) begin
			off = pc - PC_C;
			case (off[5:0])
				6'd0: m = mo(OP_MAX, 7'd25, S_FL, 7'd25);
				6'd1: m = mo(OP_MAX, 7'd29, S_FL, 7'd29);
				6'd2: m = mo(OP_MAX, 7'd30, S_FL, 7'd30);
				6'd3: m = mo(OP_MAX, 7'd34, S_FL, 7'd34);
				6'd4: m = mo(OP_MUL, 7'd25, 7'd26, 7'd35);
				6'd5: m = mo(OP_MUL, 7'd25, 7'd27, 7'd36);
				6'd6: m = mo(OP_MUL, 7'd25, 7'd28, 7'd37);
				6'd7: m = mo(OP_MUL, 7'd30, 7'd31, 7'd38);
				6'd8: m = mo(OP_MUL, 7'd30, 7'd32, 7'd39);
				6'd9: m = mo(OP_MUL, 7'd30, 7'd33, 7'd40);
				6'd10: m = mo(OP_DIV, 7'd29, 7'd15, 7'd16);
				6'd11: m = mo(OP_MUL, 7'd26, 7'd26, 7'd17);
				6'd12: m = mo(OP_MUL, 7'd27, 7'd27, 7'd18);
				6'd13: m = mo(OP_ADD, 7'd17, 7'd18, 7'd17);
				6'd14: m = mo(OP_MUL, 7'd28, 7'd28, 7'd18);
				6'd15: m = mo(OP_ADD, 7'd17, 7'd18, 7'd17);
				6'd16: m = mo(OP_MUL, S_HALF, 7'd25, 7'd18);
				6'd17: m = mo(OP_MUL, 7'd18, 7'd17, 7'd18);
				6'd18: m = mo(OP_ADD, 7'd16, 7'd18, 7'd41);
				6'd19: m = mo(OP_DIV, 7'd34, 7'd15, 7'd16);
				6'd20: m = mo(OP_MUL, 7'd31, 7'd31, 7'd17);
				6'd21: m = mo(OP_MUL, 7'd32, 7'd32, 7'd18);
				6'd22: m = mo(OP_ADD, 7'd17, 7'd18, 7'd17);
				6'd23: m = mo(OP_MUL, 7'd33, 7'd33, 7'd18);
				6'd24: m = mo(OP_ADD, 7'd17, 7'd18, 7'd17);
				6'd25: m = mo(OP_MUL, S_HALF, 7'd30, 7'd18);
				6'd26: m = mo(OP_MUL, 7'd18, 7'd17, 7'd18);
				6'd27: m = mo(OP_ADD, 7'd16, 7'd18, 7'd42);
				6'd28: m = mo(OP_MUL, S_HALF, S_DTDX, 7'd43);
				6'd29: m = mo(OP_SUB, 7'd35, 7'd38, 7'd16);
				6'd30: m = mo(OP_MUL, 7'd43, 7'd16, 7'd16);
				6'd31: m = mo(OP_ADD, 7'd25, 7'd16, D_OUT + 7'd0);
				6'd32: m = mo(OP_ADD, 7'd30, 7'd16, D_OUT + 7'd5);
				6'd33: m = mo(OP_MUL, 7'd35, 7'd26, 7'd16);
				6'd34: m = mo(OP_ADD, 7'd16, 7'd29, 7'd16);
				6'd35: m = mo(OP_MUL, 7'd38, 7'd31, 7'd17);
				6'd36: m = mo(OP_ADD, 7'd17, 7'd34, 7'd17);
				6'd37: m = mo(OP_SUB, 7'd16, 7'd17, 7'd16);
				6'd38: m = mo(OP_MUL, 7'd43, 7'd16, 7'd16);
				6'd39: m = mo(OP_ADD, 7'd35, 7'd16, D_OUT + 7'd1);
				6'd40: m = mo(OP_ADD, 7'd38, 7'd16, D_OUT + 7'd6);
				6'd41: m = mo(OP_MUL, 7'd35, 7'd27, 7'd16);
				6'd42: m = mo(OP_MUL, 7'd38, 7'd32, 7'd17);
				6'd43: m = mo(OP_SUB, 7'd16, 7'd17, 7'd16);
				6'd44: m = mo(OP_MUL, 7'd43, 7'd16, 7'd16);
				6'd45: m = mo(OP_ADD, 7'd36, 7'd16, D_OUT + 7'd2);
				6'd46: m = mo(OP_ADD, 7'd39, 7'd16, D_OUT + 7'd7);
				6'd47: m = mo(OP_MUL, 7'd35, 7'd28, 7'd16);
				6'd48: m = mo(OP_MUL, 7'd38, 7'd33, 7'd17);
				6'd49: m = mo(OP_SUB, 7'd16, 7'd17, 7'd16);
				6'd50: m = mo(OP_MUL, 7'd43, 7'd16, 7'd16);
				6'd51: m = mo(OP_ADD, 7'd37, 7'd16, D_OUT + 7'd3);
				6'd52: m = mo(OP_ADD, 7'd40, 7'd16, D_OUT + 7'd8);
				6'd53: m = mo(OP_ADD, 7'd41, 7'd29, 7'd16);
				6'd54: m = mo(OP_MUL, 7'd16, 7'd26, 7'd16);
				6'd55: m = mo(OP_ADD, 7'd42, 7'd34, 7'd17);
				6'd56: m = mo(OP_MUL, 7'd17, 7'd31, 7'd17);
				6'd57: m = mo(OP_SUB, 7'd16, 7'd17, 7'd16);
				6'd58: m = mo(OP_MUL, 7'd43, 7'd16, 7'd16);
				6'd59: m = mo(OP_ADD, 7'd41, 7'd16, D_OUT + 7'd4);
				6'd60: m = mo(OP_ADD, 7'd42, 7'd16, D_OUT + 7'd9);
				default: m = mo(OP_NOP, S_ZERO, S_ZERO, 7'd0);
			endcase
		end else if (pc < PC_END) begin
			// shift the window: newer cell to older, current cell to newer
			off = pc - PC_SH;
			i7 = {3'd0, off[3:0]};
			m = mo(OP_ADD, i7 + 7'd5, S_ZERO, i7);
		end else begin
			m = mo(OP_END, S_ZERO, S_ZERO, 7'd0);
		end
		return m;
	endfunction

endpackage

// File: design/plmir_div.sv
// Restoring divider, one quotient bit per cycle, fixed-point scaled and saturated.
module plmir_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  plmir_pkg::word_t    a,
	input  plmir_pkg::word_t    b,
	output logic                done,
	output plmir_pkg::word_t    q
);

	localparam int W = plmir_pkg::WORD_BITS;
	localparam int N = plmir_pkg::DIV_STEPS;
	localparam int CW = $clog2(N + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [N-1:0]  dvd_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  ub_q;
	logic [N-1:0]  quo_q;
	logic          neg_q;
	logic          zero_q;
	logic          apos_q;
	logic [W:0]    rem_n;
	logic [W:0]    rem_d;
	logic          ge;

	always_comb begin
		rem_n = {rem_q, dvd_q[N-1]};
		ge = rem_n >= {1'b0, ub_q};
		rem_d = ge ? (rem_n - {1'b0, ub_q}) : rem_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CW'(N);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ub_q <= plmir_pkg::mag(b);
			dvd_q <= {plmir_pkg::mag(a), {plmir_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= a[W-1] != b[W-1];
			zero_q <= b == '0;
			apos_q <= !a[W-1];
		end else if (run_q) begin
			dvd_q <= {dvd_q[N-2:0], 1'b0};
			rem_q <= rem_d[W-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign done = done_q;
	assign q = zero_q ? (apos_q ? plmir_pkg::MAXV : plmir_pkg::MINV)
		: plmir_pkg::sat_mag(neg_q, quo_q);

endmodule

// File: design/plmir_ctrl.sv
// Micro-program sequencer for the reconstruction core.
module plmir_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cell_valid,
	input  logic              row_start,
	output logic              cell_stall,
	input  plmir_pkg::sts_t   sts,
	output plmir_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_DWAIT, S_WB, S_PUB} state_t;

	localparam logic [1:0] HELD_FULL = 2'd2;

	state_t           state_q;
	logic [7:0]       pc_q;
	logic [1:0]       held_q;
	logic             emit_q;
	plmir_pkg::mop_t  ir_q;
	plmir_pkg::mop_t  cur;
	logic             is_op;

	always_comb begin
		cur = plmir_pkg::mop(pc_q);
		is_op = cur.op != plmir_pkg::OP_NOP && cur.op != plmir_pkg::OP_BR
			&& cur.op != plmir_pkg::OP_END;
		cmd.mop = (state_q == S_FETCH) ? cur : ir_q;
		cmd.load = state_q == S_IDLE && cell_valid;
		cmd.rd = state_q == S_FETCH && is_op;
		cmd.ex = state_q == S_EXEC;
		cmd.wb = state_q == S_WB;
		cmd.publish = state_q == S_PUB && emit_q && sts.out_free;
		cell_stall = state_q != S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			held_q <= '0;
			emit_q <= 1'b0;
			ir_q <= plmir_pkg::mo(plmir_pkg::OP_NOP, plmir_pkg::S_ZERO, plmir_pkg::S_ZERO,
				7'd0);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cell_valid) begin
						if (row_start)
							held_q <= '0;
						pc_q <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					case (cur.op)
						plmir_pkg::OP_NOP: pc_q <= pc_q + 1'b1;
						plmir_pkg::OP_BR: begin
							emit_q <= held_q == HELD_FULL;
							pc_q <= (held_q == HELD_FULL) ? plmir_pkg::PC_B : plmir_pkg::PC_SH;
						end
						plmir_pkg::OP_END: state_q <= S_PUB;
						default: begin
							ir_q <= cur;
							state_q <= S_EXEC;
						end
					endcase
				end
				S_EXEC: begin
					state_q <= (ir_q.op == plmir_pkg::OP_DIV) ? S_DWAIT : S_WB;
				end
				S_DWAIT: begin
					if (sts.div_done)
						state_q <= S_WB;
				end
				S_WB: begin
					pc_q <= pc_q + 1'b1;
					state_q <= S_FETCH;
				end
				S_PUB: begin
					if (!emit_q || sts.out_free) begin
						if (held_q != HELD_FULL)
							held_q <= held_q + 1'b1;
						emit_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/plmir_dpath.sv
// Datapath: configuration, register file, shared ALU and multiplier, divider, output register.
module plmir_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [plmir_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [plmir_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  plmir_pkg::cell_t                      cell_data,
	input  plmir_pkg::cmd_t                       cmd,
	output plmir_pkg::sts_t                       sts,
	output logic                                  iface_valid,
	input  logic                                  iface_stall,
	output plmir_pkg::iface_t                     iface
);

	localparam int W = plmir_pkg::WORD_BITS;
	localparam int F = plmir_pkg::FRAC_BITS;

	logic [18:0]        gamma_q;
	logic [30:0]        dtdx_q;
	logic [16:0]        floor_q;
	logic [17:0]        beta_q;
	plmir_pkg::cell_t   in_q;
	plmir_pkg::word_t   rf_q [64];
	plmir_pkg::word_t   stage_q [10];
	plmir_pkg::word_t   opa_q, opb_q, alu_q;
	plmir_pkg::word_t   spec_a, spec_b, res, div_q;
	logic [2*W-1:0]     prod_q;
	logic               pneg_q;
	logic               flag_q;
	logic               valid_q;
	plmir_pkg::iface_t  iface_q;
	logic               div_done;

	function automatic plmir_pkg::word_t special(input logic [6:0] c);
		case (c)
			plmir_pkg::S_HALF: return plmir_pkg::HALF_Q;
			plmir_pkg::S_ONE: return plmir_pkg::ONE_Q;
			plmir_pkg::S_GAMMA: return W'(gamma_q);
			plmir_pkg::S_FL: return W'(floor_q);
			plmir_pkg::S_BETA: return W'(beta_q);
			plmir_pkg::S_DTDX: return W'(dtdx_q);
			plmir_pkg::S_IN0: return in_q.density;
			plmir_pkg::S_IN1: return in_q.momentum_x;
			plmir_pkg::S_IN2: return in_q.momentum_y;
			plmir_pkg::S_IN3: return in_q.momentum_z;
			plmir_pkg::S_IN4: return in_q.energy;
			default: return '0;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= plmir_pkg::GAMMA_RST;
			dtdx_q <= plmir_pkg::DTDX_RST;
			floor_q <= plmir_pkg::FLOOR_RST;
			beta_q <= plmir_pkg::BETA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				plmir_pkg::CFG_GAMMA: gamma_q <= cfg_data[18:0];
				plmir_pkg::CFG_DTDX: dtdx_q <= cfg_data[30:0];
				plmir_pkg::CFG_FLOOR: floor_q <= cfg_data[16:0];
				plmir_pkg::CFG_BETA: beta_q <= cfg_data[17:0];
				default: gamma_q <= gamma_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			in_q <= cell_data;
	end

	always_comb begin
		spec_a = special(cmd.mop.a);
		spec_b = special(cmd.mop.b);
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			opa_q <= cmd.mop.a[6] ? spec_a : rf_q[cmd.mop.a[5:0]];
			opb_q <= cmd.mop.b[6] ? spec_b : rf_q[cmd.mop.b[5:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ex) begin
			case (cmd.mop.op)
				plmir_pkg::OP_ADD: alu_q <= plmir_pkg::sat_add(opa_q, opb_q);
				plmir_pkg::OP_SUB: alu_q <= plmir_pkg::sat_sub(opa_q, opb_q);
				plmir_pkg::OP_MAX: alu_q <= (opa_q > opb_q) ? opa_q : opb_q;
				plmir_pkg::OP_MIN: alu_q <= (opa_q < opb_q) ? opa_q : opb_q;
				plmir_pkg::OP_SEL: alu_q <= flag_q ? opb_q : opa_q;
				plmir_pkg::OP_MUL: begin
					prod_q <= plmir_pkg::mag(opa_q) * plmir_pkg::mag(opb_q);
					pneg_q <= opa_q[W-1] != opb_q[W-1];
				end
				default: alu_q <= alu_q;
			endcase
		end
	end

	plmir_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ex && cmd.mop.op == plmir_pkg::OP_DIV),
		.a      (opa_q),
		.b      (opb_q),
		.done   (div_done),
		.q      (div_q)
	);

	always_comb begin
		case (cmd.mop.op)
			plmir_pkg::OP_MUL: res = plmir_pkg::sat_mag(pneg_q, prod_q[2*W-1:F]);
			plmir_pkg::OP_DIV: res = div_q;
			default: res = alu_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			if (cmd.mop.dst[6]) begin
				if (cmd.mop.dst[3:0] < 4'd10)
					stage_q[cmd.mop.dst[3:0]] <= res;
			end else begin
				rf_q[cmd.mop.dst[5:0]] <= res;
			end
			if (cmd.mop.op == plmir_pkg::OP_SUB)
				flag_q <= res[W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.publish)
			valid_q <= 1'b1;
		else if (!iface_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			iface_q.left_density <= stage_q[0];
			iface_q.left_mom_x <= stage_q[1];
			iface_q.left_mom_y <= stage_q[2];
			iface_q.left_mom_z <= stage_q[3];
			iface_q.left_energy <= stage_q[4];
			iface_q.right_density <= stage_q[5];
			iface_q.right_mom_x <= stage_q[6];
			iface_q.right_mom_y <= stage_q[7];
			iface_q.right_mom_z <= stage_q[8];
			iface_q.right_energy <= stage_q[9];
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_free = !valid_q || !iface_stall;
	assign iface_valid = valid_q;
	assign iface = iface_q;

endmodule

// File: design/plm_interface_reconstruct_core.sv
// Top level: piecewise linear interface reconstruction, one cell in, left/right states out.
// Each item runs as a micro-program on one shared ALU and 32x32 multiplier; every operation
// is fetched, executed and written back, a divide waiting on the one-bit-per-cycle divider
// (48 bits). Full window: 166 operations with 5 divides; an item that only fills the window
// gives no result. The next cell is accepted only when the current one is finished.
// Reset clears the controller, window count, output valid and loads register defaults.
module plm_interface_reconstruct_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [plmir_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [plmir_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                  cell_valid,
	output logic                                  cell_stall,
	input  plmir_pkg::cell_t                      cell_data,
	output logic                                  iface_valid,
	input  logic                                  iface_stall,
	output plmir_pkg::iface_t                     iface
);

	`include "plm_interface_reconstruct_core_defines.svh"

	plmir_pkg::cmd_t cmd;
	plmir_pkg::sts_t sts;

	plmir_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.row_start  (cell_data.row_start),
		.cell_stall (cell_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	plmir_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cell_data   (cell_data),
		.cmd         (cmd),
		.sts         (sts),
		.iface_valid (iface_valid),
		.iface_stall (iface_stall),
		.iface       (iface)
	);

	`PLMIR_ASSERT(a_pub_free, cmd.publish |-> (!iface_valid || !iface_stall))
	`PLMIR_ASSERT(a_valid_src, $rose(iface_valid) |-> $past(cmd.publish))
	`PLMIR_ASSERT(a_ex_wb_excl, !(cmd.ex && cmd.wb) && !(cmd.load && cmd.rd))
	`PLMIR_ASSERT_RST(a_rst_out, !arst_n |-> (!iface_valid && !cell_stall))

endmodule
